// ===== design/eabv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the yaw/pitch basis core.
package eabv_pkg;

  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [61:0] Q30_HALF     = 62'h2000_0000;
  localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  localparam int unsigned HORNER_STEPS = 6;
  localparam int unsigned TAYLOR_DIV [HORNER_STEPS] = '{156, 110, 72, 42, 20, 6};

  localparam int unsigned SIN_STAGES   = 3 + 3 * HORNER_STEPS + 1;
  localparam int unsigned BASIS_STAGES = 2;
  localparam int unsigned PIPE_DEPTH   = SIN_STAGES + BASIS_STAGES;

  typedef struct packed {
    logic        neg;
    logic [30:0] mag;
  } sm_t;

  typedef struct packed {
    logic [1:0]  quad;
    logic [30:0] x;
    logic [31:0] x2;
    logic [30:0] t;
  } hstate_t;

  typedef struct packed {
    logic signed [15:0] forward_x;
    logic signed [15:0] forward_y;
    logic signed [15:0] forward_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } result_t;

  function automatic sm_t mul_q30(sm_t a, sm_t b);
    logic [61:0] p;
    sm_t         r;
    p     = 62'(a.mag) * 62'(b.mag) + Q30_HALF;
    r.mag = p[60:30];
    r.neg = a.neg ^ b.neg;
    return r;
  endfunction

  function automatic sm_t negate(sm_t a);
    sm_t r;
    r     = a;
    r.neg = ~a.neg;
    return r;
  endfunction

endpackage

// ===== design/eabv_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one yaw/pitch angle pair per beat.
interface eabv_in_if #(
  parameter int ANGLE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] yaw_angle;
  logic [ANGLE_BITS-1:0] pitch_angle;

  modport source (output valid, output yaw_angle, output pitch_angle, input ready);
  modport sink   (input valid, input yaw_angle, input pitch_angle, output ready);
endinterface

// ===== design/eabv_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: forward, right and up vectors in signed fixed point per beat.
interface eabv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] forward_x;
  logic signed [15:0] forward_y;
  logic signed [15:0] forward_z;
  logic signed [15:0] right_x;
  logic signed [15:0] right_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;

  modport source (
    output valid, output forward_x, output forward_y, output forward_z,
    output right_x, output right_z, output up_x, output up_y, output up_z,
    input ready
  );
  modport sink (
    input valid, input forward_x, input forward_y, input forward_z,
    input right_x, input right_z, input up_x, input up_y, input up_z,
    output ready
  );
endinterface

// ===== design/eabv_horner_step.sv =====
`timescale 1ns / 1ps
// One Horner step of the sine series: t = 1 - floor(floor(x2 * t) / K), three stages.
module eabv_horner_step import eabv_pkg::*; #(
  parameter int unsigned K = 6
) (
  input  logic    clk_i,
  input  logic    [2:0] en_i,
  input  hstate_t st_i,
  output hstate_t st_o
);

  localparam logic [31:0] KW    = 32'(K);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(K));

  hstate_t     a_q, b_q, c_q;
  logic [31:0] av_q, bv_q, qe_q;
  logic [62:0] prod_a;
  logic [63:0] prod_b;
  logic [31:0] qk, rem, quo;

  assign prod_a = 63'(st_i.x2) * 63'(st_i.t);
  assign prod_b = 64'(av_q) * 64'(RECIP);

  // reciprocal estimate is low by at most one
  assign qk  = qe_q * KW;
  assign rem = bv_q - qk;
  assign quo = (rem >= KW) ? qe_q + 32'd1 : qe_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q  <= st_i;
      av_q <= prod_a[61:30];
    end
    if (en_i[1]) begin
      b_q  <= a_q;
      bv_q <= av_q;
      qe_q <= prod_b[63:32];
    end
    if (en_i[2]) begin
      c_q.quad <= b_q.quad;
      c_q.x    <= b_q.x;
      c_q.x2   <= b_q.x2;
      c_q.t    <= 31'(32'(Q30_ONE) - quo);
    end
  end

  assign st_o = c_q;

endmodule

// ===== design/eabv_sine.sv =====
`timescale 1ns / 1ps
// Pipelined Q30 sine of a 32-bit phase: quadrant fold, radian scale, Horner series.
module eabv_sine import eabv_pkg::*; (
  input  logic                  clk_i,
  input  logic [SIN_STAGES-1:0] en_i,
  input  logic [31:0]           phase_i,
  output sm_t                   res_o
);

  logic [1:0]  quad0_q, quad1_q;
  logic [30:0] r_q, x_q;
  logic [30:0] r_d;
  logic [61:0] px, px2, pf;
  hstate_t     h [HORNER_STEPS+1];
  hstate_t     h0_q;
  logic [31:0] s;
  sm_t         res_q;

  assign r_d = phase_i[30] ? Q30_ONE - {1'b0, phase_i[29:0]} : {1'b0, phase_i[29:0]};
  assign px  = 62'(r_q) * 62'(HALF_PI_Q30);
  assign px2 = 62'(x_q) * 62'(x_q);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      quad0_q <= phase_i[31:30];
      r_q     <= r_d;
    end
    if (en_i[1]) begin
      quad1_q <= quad0_q;
      x_q     <= px[60:30];
    end
    if (en_i[2]) begin
      h0_q.quad <= quad1_q;
      h0_q.x    <= x_q;
      h0_q.x2   <= px2[61:30];
      h0_q.t    <= Q30_ONE;
    end
  end

  assign h[0] = h0_q;

  for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_step
    eabv_horner_step #(
      .K (TAYLOR_DIV[g])
    ) u_step (
      .clk_i (clk_i),
      .en_i  (en_i[3 + 3 * g +: 3]),
      .st_i  (h[g]),
      .st_o  (h[g+1])
    );
  end

  assign pf = 62'(h[HORNER_STEPS].x) * 62'(h[HORNER_STEPS].t);
  assign s  = pf[61:30];

  always_ff @(posedge clk_i) begin
    if (en_i[SIN_STAGES-1]) begin
      res_q.mag <= (s > 32'(Q30_ONE)) ? Q30_ONE : s[30:0];
      res_q.neg <= h[HORNER_STEPS].quad[1] && (s != 32'd0);
    end
  end

  assign res_o = res_q;

endmodule

// ===== design/eabv_basis.sv =====
`timescale 1ns / 1ps
// Basis assembly: sine/cosine products, then rounding and saturation to the output format.
module eabv_basis import eabv_pkg::*; #(
  parameter int FRACTION_BITS = 14
) (
  input  logic                    clk_i,
  input  logic [BASIS_STAGES-1:0] en_i,
  input  sm_t                     sy_i,
  input  sm_t                     cy_i,
  input  sm_t                     sp_i,
  input  sm_t                     cp_i,
  output result_t                 res_o
);

  localparam int          SHIFT      = 30 - FRACTION_BITS;
  localparam logic [31:0] ROUND_HALF = (32'd1 << SHIFT) >> 1;
  localparam logic [30:0] ONE_OUT    = 31'd1 << FRACTION_BITS;

  sm_t     fx_q, fy_q, fz_q, rx_q, rz_q, ux_q, uy_q, uz_q;
  result_t res_q;

  function automatic logic signed [15:0] to_fix(sm_t v);
    logic [31:0] rnd;
    logic [30:0] m;
    logic [30:0] negm;
    rnd  = (32'(v.mag) + ROUND_HALF) >> SHIFT;
    m    = (rnd > 32'(ONE_OUT)) ? ONE_OUT : rnd[30:0];
    negm = ~m + 31'd1;
    return (v.neg && m != 31'd0) ? signed'(negm[15:0]) : signed'(m[15:0]);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      fx_q <= mul_q30(cp_i, sy_i);
      fy_q <= sp_i;
      fz_q <= mul_q30(cp_i, cy_i);
      rx_q <= negate(cy_i);
      rz_q <= sy_i;
      ux_q <= negate(mul_q30(sy_i, sp_i));
      uy_q <= cp_i;
      uz_q <= negate(mul_q30(cy_i, sp_i));
    end
    if (en_i[1]) begin
      res_q.forward_x <= to_fix(fx_q);
      res_q.forward_y <= to_fix(fy_q);
      res_q.forward_z <= to_fix(fz_q);
      res_q.right_x   <= to_fix(rx_q);
      res_q.right_z   <= to_fix(rz_q);
      res_q.up_x      <= to_fix(ux_q);
      res_q.up_y      <= to_fix(uy_q);
      res_q.up_z      <= to_fix(uz_q);
    end
  end

  assign res_o = res_q;

endmodule

// ===== design/euler_angle_basis_vectors_core.sv =====
`timescale 1ns / 1ps
// Top level of the yaw/pitch to forward/right/up basis core.
//
// Takes one yaw/pitch pair per beat (binary angle units, a full turn is 2^ANGLE_BITS) and
// returns forward, right and up vectors in signed Q1.FRACTION_BITS, saturated at +/-1.0.
// One pair can be accepted every cycle while ready is high. The depth is set by the sine
// units: quadrant fold, radian scaling, squaring and six Horner steps of three stages each
// (multiply, reciprocal multiply, remainder correction), followed by the product and
// rounding stages and the output register. A one-beat skid register behind the output lets
// one further beat in while a result is held; after that the whole pipeline holds and ready
// drops until the result is taken. No reset sweep.
module euler_angle_basis_vectors_core import eabv_pkg::*; #(
  parameter int ANGLE_BITS    = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  eabv_in_if.sink    item_i,
  eabv_out_if.source result_o
);

  localparam int PHASE_SHIFT = 32 - ANGLE_BITS;

  logic [31:0]           py, pp;
  logic                  en;
  logic [PIPE_DEPTH-1:0] valid_q;
  logic [PIPE_DEPTH-1:0] stage_en;
  sm_t                   sy, cy, sp, cp;
  result_t               basis_res;
  result_t               out_q, skid_q;
  logic                  out_valid_q, skid_valid_q;

  assign py = 32'(item_i.yaw_angle[ANGLE_BITS-1:0]) << PHASE_SHIFT;
  assign pp = 32'(item_i.pitch_angle[ANGLE_BITS-1:0]) << PHASE_SHIFT;

  assign en           = ~skid_valid_q;
  assign item_i.ready = en;

  assign stage_en = {PIPE_DEPTH{en}} & {valid_q[PIPE_DEPTH-2:0], item_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[PIPE_DEPTH-2:0], item_i.valid};
    end
  end

  eabv_sine u_sin_yaw (
    .clk_i   (clk_i),
    .en_i    (stage_en[SIN_STAGES-1:0]),
    .phase_i (py),
    .res_o   (sy)
  );

  eabv_sine u_cos_yaw (
    .clk_i   (clk_i),
    .en_i    (stage_en[SIN_STAGES-1:0]),
    .phase_i (py + QUARTER_TURN),
    .res_o   (cy)
  );

  eabv_sine u_sin_pitch (
    .clk_i   (clk_i),
    .en_i    (stage_en[SIN_STAGES-1:0]),
    .phase_i (pp),
    .res_o   (sp)
  );

  eabv_sine u_cos_pitch (
    .clk_i   (clk_i),
    .en_i    (stage_en[SIN_STAGES-1:0]),
    .phase_i (pp + QUARTER_TURN),
    .res_o   (cp)
  );

  eabv_basis #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_basis (
    .clk_i (clk_i),
    .en_i  (stage_en[PIPE_DEPTH-1:SIN_STAGES]),
    .sy_i  (sy),
    .cy_i  (cy),
    .sp_i  (sp),
    .cp_i  (cp),
    .res_o (basis_res)
  );

  // output register with one-beat skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (result_o.ready) begin
        skid_valid_q <= 1'b0;
      end
    end else if (valid_q[PIPE_DEPTH-1]) begin
      if (out_valid_q && !result_o.ready) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (result_o.ready) begin
        out_q <= skid_q;
      end
    end else if (valid_q[PIPE_DEPTH-1]) begin
      if (out_valid_q && !result_o.ready) begin
        skid_q <= basis_res;
      end else begin
        out_q <= basis_res;
      end
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.forward_x = out_q.forward_x;
  assign result_o.forward_y = out_q.forward_y;
  assign result_o.forward_z = out_q.forward_z;
  assign result_o.right_x   = out_q.right_x;
  assign result_o.right_z   = out_q.right_z;
  assign result_o.up_x      = out_q.up_x;
  assign result_o.up_y      = out_q.up_y;
  assign result_o.up_z      = out_q.up_z;

endmodule

// ===== tb/euler_angle_basis_vectors_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the yaw/pitch basis core: predicts each basis and checks it per beat.
module euler_angle_basis_vectors_core_tb;

  localparam int ANGLE_BITS     = 16;
  localparam int FRACTION_BITS  = 14;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic [63:0] UNIT_Q30    = 64'd1 << 30;
  localparam logic [63:0] RAD_SCALE   = 64'd1686629713;
  localparam logic [31:0] QUARTER_PHS = eabv_pkg::QUARTER_TURN;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } q30_val_t;

  logic clk;
  logic rst_n;

  eabv_in_if #(.ANGLE_BITS(ANGLE_BITS)) angle_bus ();
  eabv_out_if                           basis_bus ();

  euler_angle_basis_vectors_core #(
    .ANGLE_BITS   (ANGLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (angle_bus),
    .result_o(basis_bus)
  );

  eabv_pkg::result_t expected_basis [$];
  int                mismatches;
  bit                source_steady;
  bit                sink_steady;
  int                sink_hold_req;
  int                sink_hold_left;
  int                sink_stall_left;
  int                idle_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Sine of a 32-bit phase, Q30 sign/magnitude, Taylor series by Horner steps
  function automatic q30_val_t phase_sine(logic [31:0] phase);
    logic [1:0]  quad;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    q30_val_t    v;
    quad = phase[31:30];
    r    = {34'd0, phase[29:0]};
    if (quad[0]) begin
      r = UNIT_Q30 - r;
    end
    x  = (r * RAD_SCALE) >> 30;
    x2 = (x * x) >> 30;
    t  = UNIT_Q30;
    for (int i = 0; i < eabv_pkg::HORNER_STEPS; i++) begin
      t = UNIT_Q30 - ((x2 * t) >> 30) / 64'(eabv_pkg::TAYLOR_DIV[i]);
    end
    s = (x * t) >> 30;
    if (s > UNIT_Q30) begin
      s = UNIT_Q30;
    end
    v.mag = s;
    v.neg = quad[1] && (s != 0);
    return v;
  endfunction

  function automatic q30_val_t q30_product(q30_val_t a, q30_val_t b);
    q30_val_t v;
    v.mag = (a.mag * b.mag + (64'd1 << 29)) >> 30;
    v.neg = a.neg ^ b.neg;
    return v;
  endfunction

  function automatic q30_val_t flip_sign(q30_val_t a);
    q30_val_t v;
    v     = a;
    v.neg = ~a.neg;
    return v;
  endfunction

  // Round half up to the output fraction, saturate at one, apply sign, keep 16 bits
  function automatic logic [15:0] to_fixed(q30_val_t v);
    logic [63:0] m;
    m = v.mag;
    if (30 - FRACTION_BITS > 0) begin
      m = (m + (64'd1 << (30 - FRACTION_BITS - 1))) >> (30 - FRACTION_BITS);
    end
    if (m > (64'd1 << FRACTION_BITS)) begin
      m = 64'd1 << FRACTION_BITS;
    end
    if (v.neg && m != 0) begin
      return 16'(64'd0 - m);
    end
    return m[15:0];
  endfunction

  function automatic eabv_pkg::result_t predict_basis(logic [ANGLE_BITS-1:0] yaw,
                                                      logic [ANGLE_BITS-1:0] pitch);
    logic [31:0]       yaw_phs;
    logic [31:0]       pitch_phs;
    q30_val_t          sin_y;
    q30_val_t          cos_y;
    q30_val_t          sin_p;
    q30_val_t          cos_p;
    q30_val_t          rgt_x;
    eabv_pkg::result_t b;
    yaw_phs   = 32'(yaw) << (32 - ANGLE_BITS);
    pitch_phs = 32'(pitch) << (32 - ANGLE_BITS);
    sin_y     = phase_sine(yaw_phs);
    cos_y     = phase_sine(yaw_phs + QUARTER_PHS);
    sin_p     = phase_sine(pitch_phs);
    cos_p     = phase_sine(pitch_phs + QUARTER_PHS);
    rgt_x     = phase_sine(yaw_phs - QUARTER_PHS);
    b.forward_x = to_fixed(q30_product(cos_p, sin_y));
    b.forward_y = to_fixed(sin_p);
    b.forward_z = to_fixed(q30_product(cos_p, cos_y));
    b.right_x   = to_fixed(rgt_x);
    b.right_z   = to_fixed(phase_sine(yaw_phs - QUARTER_PHS + QUARTER_PHS));
    b.up_x      = to_fixed(flip_sign(q30_product(sin_y, sin_p)));
    b.up_y      = to_fixed(cos_p);
    b.up_z      = to_fixed(flip_sign(q30_product(cos_y, sin_p)));
    return b;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int draw_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      return 0;
    end
    if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Uniform angle, or one close to a quadrant boundary
  function automatic logic [ANGLE_BITS-1:0] draw_angle();
    int base;
    if ($urandom_range(3) == 0) begin
      base = $urandom_range(3) * (1 << (ANGLE_BITS - 2));
      return ANGLE_BITS'(base + $urandom_range(6) - 3);
    end
    return ANGLE_BITS'($urandom);
  endfunction

  task automatic send_angles(logic [ANGLE_BITS-1:0] yaw, logic [ANGLE_BITS-1:0] pitch);
    int gap;
    @(negedge clk);
    gap = source_steady ? 0 : draw_gap();
    if (gap > 0) begin
      angle_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    angle_bus.valid       = 1'b1;
    angle_bus.yaw_angle   = yaw;
    angle_bus.pitch_angle = pitch;
    do @(posedge clk); while (!(angle_bus.valid && angle_bus.ready));
    expected_basis.insert(expected_basis.size(), predict_basis(yaw, pitch));
  endtask

  task automatic release_source();
    @(negedge clk);
    angle_bus.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_basis.size() != 0) @(posedge clk);
  endtask

  task automatic test_landmark_angles();
    logic [15:0] yaws   [20] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
                                 16'h0000, 16'h0000, 16'h2000, 16'h6000, 16'hA000,
                                 16'hE000, 16'h3FFF, 16'h4001, 16'h7FFF, 16'h8001,
                                 16'hBFFF, 16'hC001, 16'h0001, 16'h5555, 16'hAAAA};
    logic [15:0] pitches[20] = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
                                 16'h4000, 16'hC000, 16'h8000, 16'h3FFF, 16'h4001,
                                 16'hBFFF, 16'hC001, 16'h7FFF, 16'h8001, 16'h2000,
                                 16'hE000, 16'h0001, 16'hFFFF, 16'hAAAA, 16'h5555};
    for (int i = 0; i < 20; i++) begin
      send_angles(yaws[i], pitches[i]);
    end
    release_source();
  endtask

  task automatic test_random_headings(int count);
    for (int i = 0; i < count; i++) begin
      send_angles(draw_angle(), draw_angle());
    end
    release_source();
  endtask

  // Sink holds off long enough for the pipeline and skid beat to fill
  task automatic test_output_backpressure();
    source_steady = 1'b1;
    @(negedge clk);
    sink_hold_req = 200;
    @(negedge clk);
    @(negedge clk);
    for (int i = 0; i < 80; i++) begin
      send_angles(draw_angle(), draw_angle());
    end
    release_source();
    source_steady = 1'b0;
  endtask

  task automatic test_drain_and_resume();
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 40; i++) begin
        send_angles(draw_angle(), draw_angle());
      end
      release_source();
      wait_drained();
    end
  endtask

  task automatic test_full_rate_stream();
    source_steady = 1'b1;
    sink_steady   = 1'b1;
    for (int i = 0; i < 300; i++) begin
      send_angles(draw_angle(), draw_angle());
    end
    release_source();
    wait_drained();
    source_steady = 1'b0;
    sink_steady   = 1'b0;
  endtask

  // Sink: random stalls, a requested long hold, or always ready
  always @(negedge clk) begin
    if (sink_hold_req > 0) begin
      sink_hold_left = sink_hold_req;
      sink_hold_req  = 0;
    end
    if (sink_hold_left > 0) begin
      basis_bus.ready = 1'b0;
      sink_hold_left--;
    end else if (sink_steady) begin
      basis_bus.ready = 1'b1;
    end else if (sink_stall_left > 0) begin
      basis_bus.ready = 1'b0;
      sink_stall_left--;
    end else begin : pick_stall
      int g;
      g = draw_gap();
      if (g == 0) begin
        basis_bus.ready = 1'b1;
      end else begin
        basis_bus.ready = 1'b0;
        sink_stall_left = g - 1;
      end
    end
  end

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_beat
    eabv_pkg::result_t want;
    if (rst_n && basis_bus.valid && basis_bus.ready) begin
      if (expected_basis.size() == 0) begin
        $error("result beat with no basis expected");
        mismatches++;
      end else begin
        want = expected_basis.pop_front();
        check_field("forward_x", want.forward_x, basis_bus.forward_x);
        check_field("forward_y", want.forward_y, basis_bus.forward_y);
        check_field("forward_z", want.forward_z, basis_bus.forward_z);
        check_field("right_x", want.right_x, basis_bus.right_x);
        check_field("right_z", want.right_z, basis_bus.right_z);
        check_field("up_x", want.up_x, basis_bus.up_x);
        check_field("up_y", want.up_y, basis_bus.up_y);
        check_field("up_z", want.up_z, basis_bus.up_z);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (angle_bus.valid && angle_bus.ready) ||
        (basis_bus.valid && basis_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst_n                 = 1'b0;
    angle_bus.valid       = 1'b0;
    angle_bus.yaw_angle   = '0;
    angle_bus.pitch_angle = '0;
    basis_bus.ready       = 1'b0;
    mismatches            = 0;
    source_steady         = 1'b0;
    sink_steady           = 1'b0;
    sink_hold_req         = 0;
    sink_hold_left        = 0;
    sink_stall_left       = 0;
    idle_cycles           = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_landmark_angles();
    test_random_headings(350);
    test_output_backpressure();
    test_drain_and_resume();
    test_full_rate_stream();
    test_random_headings(380);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_basis.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
